// ===== rtl/fpabd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpabd_pkg
// Types and constants shared by the fixed-probability bin decoder modules.
// ----------------------------------------------------------------------------
package fpabd_pkg;

    localparam int RANGE_W   = 9;
    localparam int VALUE_W   = 10;
    localparam int LEN_W     = 24;
    localparam int READS_W   = 25;
    localparam int LPS_W     = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [RANGE_W-1:0] RANGE_START  = 9'd510;
    localparam logic [READS_W-1:0] INIT_READS   = 25'd9;
    localparam logic [READS_W-1:0] BUDGET_EXTRA = 25'd10;
    localparam logic [LPS_W-1:0]   LPS_MIN      = 8'd6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LPS_Q0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LPS_Q3 = 8'd3;

    localparam logic [LPS_W-1:0] LPS_RESET [4] = '{8'd128, 8'd176, 8'd208, 8'd240};

    // one queued read operation
    typedef struct packed {
        logic start;      // new partition, reload range and value
        logic no_double;  // initial read, range is not doubled
        logic cbit;       // coded bit after the length cut
        logic try_bins;   // bins may follow this read
    } fpabd_op_t;

    typedef enum logic {
        ST_POP,
        ST_BINS
    } fpabd_state_t;

endpackage

// ===== rtl/fpabd_front.sv =====
// ----------------------------------------------------------------------------
// fpabd_front
// Accepts coded bits, tracks partition length and read budget, and queues
// one read operation per item that can still lead to bins.
// ----------------------------------------------------------------------------
module fpabd_front import fpabd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // partition_bits[23:0], coded_bit[24], zero pad
    input  logic        s_tuser,   // first
    input  logic        q_full,
    output logic        q_push,
    output fpabd_op_t   q_op
);

    logic               active_reg, active_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [READS_W-1:0] reads_reg, reads_next;

    logic               accept;
    logic               act;
    logic [READS_W-1:0] rd;
    logic [READS_W-1:0] rd_inc;
    logic [READS_W-1:0] budget;
    logic               ok;
    logic [LEN_W-1:0]   bits_in;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign bits_in  = s_tdata[LEN_W-1:0];

    always_comb begin
        act         = s_tuser ? (bits_in != '0) : active_reg;
        len_next    = s_tuser ? bits_in : len_reg;
        rd          = s_tuser ? '0 : reads_reg;
        rd_inc      = rd + 25'd1;
        budget      = {1'b0, len_next} + BUDGET_EXTRA;
        ok          = rd_inc < budget;
        active_next = act && ok;
        reads_next  = act ? rd_inc : rd;

        q_push            = accept && act && ok;
        q_op.start        = s_tuser;
        q_op.no_double    = rd < INIT_READS;
        q_op.cbit         = (rd < {1'b0, len_next}) ? s_tdata[LEN_W] : 1'b0;
        q_op.try_bins     = rd_inc >= INIT_READS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            len_reg    <= '0;
            reads_reg  <= '0;
        end else if (accept) begin
            active_reg <= active_next;
            len_reg    <= len_next;
            reads_reg  <= reads_next;
        end
    end

endmodule

// ===== rtl/fpabd_queue.sv =====
// ----------------------------------------------------------------------------
// fpabd_queue
// Short first-in first-out queue of read operations between front and back.
// ----------------------------------------------------------------------------
module fpabd_queue import fpabd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_en,
    input  fpabd_op_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output fpabd_op_t rd_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fpabd_op_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = count_reg == CNT_FULL;
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fpabd_back.sv =====
// ----------------------------------------------------------------------------
// fpabd_back
// Arithmetic decoding engine: shifts queued bits into the offset value and
// decodes one bin per cycle, while the output is free, as long as range stays at 256 or above.
// ----------------------------------------------------------------------------
module fpabd_back import fpabd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 op_valid,
    input  fpabd_op_t            op,
    output logic                 op_ready,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LPS_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_bin,
    output logic                 out_last
);

    fpabd_state_t       state_reg, state_next;
    logic [RANGE_W-1:0] range_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [LPS_W-1:0]   lps_reg [4];
    logic               out_valid_reg, out_bin_reg, out_last_reg;

    logic               out_free;
    logic               bin_fire;
    logic               pop;
    logic [RANGE_W-1:0] base_range, range_sh;
    logic [VALUE_W-1:0] base_value, value_sh;
    logic [LPS_W-1:0]   lps_raw, lps;
    logic [RANGE_W-1:0] range_sub;
    logic               is_mps;
    logic [RANGE_W-1:0] range_nx;
    logic [VALUE_W-1:0] value_nx;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = op_valid && op_ready;
    assign out_valid = out_valid_reg;
    assign out_bin   = out_bin_reg;
    assign out_last  = out_last_reg;

    // datapath
    always_comb begin
        base_range = op.start ? RANGE_START : range_reg;
        base_value = op.start ? '0 : value_reg;
        range_sh   = op.no_double ? base_range : {base_range[RANGE_W-2:0], 1'b0};
        value_sh   = {base_value[VALUE_W-2:0], op.cbit};

        lps_raw    = lps_reg[range_reg[7:6]];
        lps        = (lps_raw < LPS_MIN) ? LPS_MIN : lps_raw;
        range_sub  = range_reg - {1'b0, lps};
        is_mps     = value_reg < {1'b0, range_sub};
        range_nx   = is_mps ? range_sub : {1'b0, lps};
        value_nx   = is_mps ? value_reg : value_reg - {1'b0, range_sub};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_POP: begin
                if (op_valid && op.try_bins && range_sh[RANGE_W-1]) begin
                    state_next = ST_BINS;
                end
            end
            ST_BINS: begin
                if (out_free && !range_nx[RANGE_W-1]) begin
                    state_next = ST_POP;
                end
            end
            default: state_next = ST_POP;
        endcase
    end

    // outputs
    always_comb begin
        op_ready = 1'b0;
        bin_fire = 1'b0;
        case (state_reg)
            ST_POP:  op_ready = 1'b1;
            ST_BINS: bin_fire = out_free;
            default: op_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_POP;
            range_reg     <= RANGE_START;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                range_reg <= range_sh;
                value_reg <= value_sh;
            end else if (bin_fire) begin
                range_reg <= range_nx;
                value_reg <= value_nx;
            end
            if (bin_fire) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bin_fire) begin
            out_bin_reg  <= !is_mps;
            out_last_reg <= !range_nx[RANGE_W-1];
        end
    end

    // lps width registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lps_reg <= LPS_RESET;
        end else if (cfg_valid && cfg_index <= REG_LPS_Q3) begin
            lps_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

endmodule

// ===== rtl/fixed_probability_arith_bin_decoder_core.sv =====
// Throughput: the decoding engine gives one bin per cycle while the receiver is ready
// and takes no new item while it decodes bins; a read queue lets the input run ahead.
// Reset: synchronous, active low on aresetn; clears the queue, the engine and
// the partition counters and reloads the lps widths 128, 176, 208, 240.
// ----------------------------------------------------------------------------
// fixed_probability_arith_bin_decoder_core
// Fixed-probability arithmetic bin decoder for one stream partition.
// ----------------------------------------------------------------------------
module fixed_probability_arith_bin_decoder_core import fpabd_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // partition_bits[23:0], coded_bit[24], zero pad
    input  logic                 s_tuser,   // first
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // bin[0], zero pad
    output logic                 m_tlast,   // last_bin
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LPS_W-1:0]     cfg_data
);

    fpabd_op_t push_op, pop_op;
    logic      q_push, q_full, q_empty, q_pop;
    logic      out_bin;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {7'd0, out_bin};

    fpabd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    fpabd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_data (push_op),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (pop_op),
        .empty   (q_empty)
    );

    fpabd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (!q_empty),
        .op        (pop_op),
        .op_ready  (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bin   (out_bin),
        .out_last  (m_tlast)
    );

endmodule

// ===== rtl/fpabd_checker.sv =====
// ----------------------------------------------------------------------------
// fpabd_checker
// Port-level checks on the bin decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module fpabd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // only the bin bit of tdata is ever set
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

    // register writes are never held off
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind fixed_probability_arith_bin_decoder_core fpabd_checker u_fpabd_checker (.*);

// ===== dv/fpabd_bin_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpabd_bin_checker
// Watches the input, result and register channels of the bin decoder, keeps
// its own copy of the decoder state, predicts the bins of every accepted
// input beat and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module fpabd_bin_checker import fpabd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,   // partition_bits[23:0], coded_bit[24], zero pad
    input  logic                 s_tuser,   // first
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,   // bin[0], zero pad
    input  logic                 m_tlast,   // last_bin
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LPS_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   bins_checked
);

    localparam logic [RANGE_W-1:0] RANGE_HALF = 9'd256;
    localparam int                 MAX_BINS   = 43;

    typedef struct packed {
        logic dec_bin;
        logic last_bin;
    } bin_beat_t;

    bin_beat_t          expected_bins[$];
    logic [LPS_W-1:0]   lps_width [4];
    logic [RANGE_W-1:0] cur_range;
    logic [VALUE_W-1:0] cur_value;
    logic [LEN_W-1:0]   part_len;
    logic [READS_W-1:0] reads_done;
    logic               decoding;

    initial begin
        fail_count   = 0;
        pending      = 0;
        bins_checked = 0;
    end

    task automatic read_bit(input logic b);
        cur_value = {cur_value[VALUE_W-2:0], b};
        if (reads_done != '1)
            reads_done = reads_done + 1'b1;
    endtask

    task automatic decode_item(input logic first, input logic [LEN_W-1:0] len,
                               input logic coded);
        logic               b;
        logic [LPS_W-1:0]   w;
        logic [READS_W-1:0] budget;
        bin_beat_t          beat;
        int                 n;
        n = 0;
        if (first) begin
            part_len   = len;
            reads_done = '0;
            cur_range  = RANGE_START;
            cur_value  = '0;
            decoding   = (len != '0);
        end
        if (!decoding)
            return;
        b = (reads_done < {1'b0, part_len}) ? coded : 1'b0;
        if (reads_done < INIT_READS) begin
            read_bit(b);
            if (reads_done < INIT_READS)
                return;
        end else begin
            cur_range = cur_range << 1;
            read_bit(b);
            if (cur_range < RANGE_HALF)
                return;
        end
        budget = {1'b0, part_len} + BUDGET_EXTRA;
        while (cur_range >= RANGE_HALF && reads_done < budget && n < MAX_BINS) begin
            w = lps_width[cur_range[7:6]];
            if (w < LPS_MIN)
                w = LPS_MIN;
            cur_range = cur_range - {1'b0, w};
            if (cur_value < {1'b0, cur_range}) begin
                beat.dec_bin = 1'b0;
            end else begin
                beat.dec_bin = 1'b1;
                cur_value = cur_value - {1'b0, cur_range};
                cur_range = {1'b0, w};
            end
            beat.last_bin = 1'b0;
            expected_bins.push_back(beat);
            n++;
        end
        if (n > 0) begin
            beat = expected_bins.pop_back();
            beat.last_bin = 1'b1;
            expected_bins.push_back(beat);
        end
        if (cur_range >= RANGE_HALF)
            decoding = 1'b0;
    endtask

    always @(posedge aclk) begin
        bin_beat_t exp_beat;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++)
                lps_width[i] = LPS_RESET[i];
            cur_range  = RANGE_START;
            cur_value  = '0;
            part_len   = '0;
            reads_done = '0;
            decoding   = 1'b0;
            expected_bins.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bins.size() == 0) begin
                    $error("unexpected bin beat: bin %0d last_bin %0d", m_tdata[0], m_tlast);
                    fail_count++;
                end else begin
                    exp_beat = expected_bins.pop_front();
                    bins_checked++;
                    if (m_tdata[0] !== exp_beat.dec_bin) begin
                        $error("bin: expected %0d, got %0d", exp_beat.dec_bin, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_beat.last_bin) begin
                        $error("last_bin: expected %0d, got %0d", exp_beat.last_bin, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready && cfg_index <= REG_LPS_Q3)
                lps_width[cfg_index[1:0]] = cfg_data;
            if (s_tvalid && s_tready)
                decode_item(s_tuser, s_tdata[LEN_W-1:0], s_tdata[LEN_W]);
        end
        pending = expected_bins.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives partitions of coded bits into the bin decoder under several lps
// width settings, with bursty input and a stalling receiver, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top import fpabd_pkg::*; ();

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int NUM_PHASES      = 5;

    localparam int LPS_MID          = 0;
    localparam int LPS_EDGES        = 1;
    localparam int LPS_OUT_OF_RANGE = 2;
    localparam int LPS_RESET_VALUES = 3;

    localparam int BITS_RANDOM = 0;
    localparam int BITS_ZERO   = 1;
    localparam int BITS_ONE    = 2;

    localparam int RX_ALWAYS = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_BURSTY = 2;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [31:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LPS_W-1:0]     cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 cfg_ready;

    int fail_count;
    int pending;
    int bins_checked;

    logic [LPS_W-1:0] lps_plan [4];
    int burst_left    = 0;
    int items_sent    = 0;
    int partitions    = 0;
    int lps_settings  = 1;
    int quiet_cycles  = 0;
    int rx_mode       = RX_ALWAYS;
    int rx_mode_left  = 0;
    int rx_stall_left = 0;
    int phase_start   = 0;

    always #5 aclk = ~aclk;

    fixed_probability_arith_bin_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fpabd_bin_checker u_bin_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .bins_checked (bins_checked)
    );

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_ALWAYS, RX_BURSTY);
            rx_mode_left = $urandom_range(16, 96);
        end else begin
            rx_mode_left--;
        end
        if (rx_stall_left != 0)
            rx_stall_left--;
        else if (rx_mode == RX_BURSTY && $urandom_range(0, 5) == 0)
            rx_stall_left = $urandom_range(1, 10);
        if (rx_mode == RX_ALWAYS)
            m_tready <= 1'b1;
        else if (rx_mode == RX_RANDOM)
            m_tready <= ($urandom_range(0, 2) != 0);
        else
            m_tready <= (rx_stall_left == 0);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("fixed_probability_arith_bin_decoder_core regression: fail");
                $finish;
            end
        end
    end

    function automatic logic pick_bit(input int mode);
        if (mode == BITS_ZERO)
            return 1'b0;
        if (mode == BITS_ONE)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // every task below starts and ends at a falling edge
    task automatic send_item(input logic first, input logic [LEN_W-1:0] len,
                             input logic cbit);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {7'd0, cbit, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_lps_plan();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_LPS_Q0 + CFG_IDX_W'(i);
            cfg_data  <= lps_plan[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        lps_settings++;
    endtask

    task automatic make_lps_plan(input int mode);
        for (int i = 0; i < 4; i++) begin
            case (mode)
                LPS_MID: begin
                    lps_plan[i] = LPS_W'($urandom_range(6, 240));
                end
                LPS_EDGES: begin
                    lps_plan[i] = $urandom_range(0, 1) ? 8'd240 : 8'd6;
                end
                LPS_OUT_OF_RANGE: begin
                    lps_plan[i] = $urandom_range(0, 1) ? LPS_W'($urandom_range(0, 5))
                                                       : LPS_W'($urandom_range(241, 255));
                end
                default: begin
                    lps_plan[i] = LPS_RESET[i];
                end
            endcase
        end
    endtask

    task automatic send_partition();
        int               kind;
        int               body;
        int               bit_mode;
        logic [LEN_W-1:0] len;
        kind     = $urandom_range(0, 99);
        bit_mode = $urandom_range(BITS_RANDOM, BITS_ONE);
        if (bit_mode != BITS_RANDOM && $urandom_range(0, 1))
            bit_mode = BITS_RANDOM;
        if (kind < 8) begin
            // empty partition
            send_item(1'b1, '0, 1'($urandom_range(0, 1)));
            return;
        end
        if (kind < 16) begin
            // huge length, cut short by the next partition
            len  = LEN_W'($urandom);
            body = $urandom_range(5, 40);
        end else begin
            len  = LEN_W'($urandom_range(1, 30));
            body = len + 10;
            if ($urandom_range(0, 6) == 0)
                body = $urandom_range(1, len + 9);
        end
        partitions++;
        send_item(1'b1, len, pick_bit(bit_mode));
        for (int i = 1; i < body; i++)
            send_item(1'b0, LEN_W'($urandom), pick_bit(bit_mode));
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                send_item(1'b0, LEN_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset widths: idle beat, empty partition, forced zeros until budget runs out
        send_item(1'b0, 24'hFFFFFF, 1'b1);
        send_item(1'b1, 24'h000000, 1'b1);
        send_item(1'b1, 24'd2, 1'b1);
        repeat (12) send_item(1'b0, 24'h000000, 1'b1);
        partitions += 2;
        settle();

        // widths below minimum saturate, a stream of zeros ending in a one gives the longest bin run
        for (int i = 0; i < 4; i++)
            lps_plan[i] = '0;
        write_lps_plan();
        send_item(1'b1, 24'hFFFFFF, 1'b0);
        repeat (8) send_item(1'b0, 24'h000000, 1'b0);
        send_item(1'b0, 24'h000000, 1'b1);
        partitions++;
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0, 3:    make_lps_plan(LPS_MID);
                1:       make_lps_plan(LPS_EDGES);
                2:       make_lps_plan(LPS_OUT_OF_RANGE);
                default: make_lps_plan(LPS_RESET_VALUES);
            endcase
            write_lps_plan();
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                send_partition();
            settle();
        end

        $display("covered %0d input beats in %0d partitions under %0d lps width settings",
                 items_sent, partitions, lps_settings);
        $display("%0d bins checked, %0d mismatches", bins_checked, fail_count);
        if (fail_count == 0)
            $display("fixed_probability_arith_bin_decoder_core regression: pass");
        else
            $display("fixed_probability_arith_bin_decoder_core regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fpabd_pkg.sv
rtl/fpabd_front.sv
rtl/fpabd_queue.sv
rtl/fpabd_back.sv
rtl/fixed_probability_arith_bin_decoder_core.sv
rtl/fpabd_checker.sv
dv/fpabd_bin_checker.sv
dv/tb_top.sv
